// ----- design/skt_pkg.sv -----
// skt_pkg: shared types and constants of the SQL keyword tokenizer.
// Token kinds, keyword patterns and the token summary carried between modules.
// No dependencies.
package skt_pkg;

    typedef enum logic [3:0] {
        KIND_SELECT   = 4'd0,
        KIND_FROM     = 4'd1,
        KIND_WHERE    = 4'd2,
        KIND_SEMI     = 4'd3,
        KIND_AND      = 4'd4,
        KIND_OR       = 4'd5,
        KIND_PLUS     = 4'd6,
        KIND_MINUS    = 4'd7,
        KIND_DIVIDE   = 4'd8,
        KIND_ASTERISK = 4'd9,
        KIND_EQUAL    = 4'd10,
        KIND_GREATER  = 4'd11,
        KIND_LESS     = 4'd12,
        KIND_STRING   = 4'd13,
        KIND_COLUMN   = 4'd14
    } kind_t;

    localparam int HEAD_BYTES = 6;
    localparam int N_PATTERNS = 13;

    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_QUOTE   = 8'd39;

    // short_len saturates at 7 for anything longer than the head
    typedef struct packed {
        logic [2:0]                  short_len;
        logic [8*HEAD_BYTES-1:0]     head;
        logic [7:0]                  first_char;
        logic [7:0]                  last_char;
    } tok_sum_t;

    typedef struct packed {
        logic emit;
        logic overflow;
    } tok_evt_t;

    typedef struct packed {
        logic [8*HEAD_BYTES-1:0] head;
        logic [2:0]              len;
        kind_t                   kind;
    } pattern_t;

    // heads are little-endian: first character in the low byte
    localparam pattern_t PATTERNS [N_PATTERNS] = '{
        '{head: 48'h5443454C4553, len: 3'd6, kind: KIND_SELECT},
        '{head: 48'h00004D4F5246, len: 3'd4, kind: KIND_FROM},
        '{head: 48'h004552454857, len: 3'd5, kind: KIND_WHERE},
        '{head: 48'h00000000003B, len: 3'd1, kind: KIND_SEMI},
        '{head: 48'h000000444E41, len: 3'd3, kind: KIND_AND},
        '{head: 48'h00000000524F, len: 3'd2, kind: KIND_OR},
        '{head: 48'h00000000002B, len: 3'd1, kind: KIND_PLUS},
        '{head: 48'h00000000002D, len: 3'd1, kind: KIND_MINUS},
        '{head: 48'h00000000002F, len: 3'd1, kind: KIND_DIVIDE},
        '{head: 48'h00000000002A, len: 3'd1, kind: KIND_ASTERISK},
        '{head: 48'h00000000003D, len: 3'd1, kind: KIND_EQUAL},
        '{head: 48'h00000000003E, len: 3'd1, kind: KIND_GREATER},
        '{head: 48'h00000000003C, len: 3'd1, kind: KIND_LESS}
    };

endpackage

// ----- design/skt_classify.sv -----
// skt_classify: maps a token summary to its token kind.
// Depends on skt_pkg.
module skt_classify
(
    input  skt_pkg::tok_sum_t sum,
    output skt_pkg::kind_t    kind
);

    logic matched;

    always_comb
    begin
        matched = 1'b0;
        kind    = skt_pkg::KIND_COLUMN;
        for (int p = 0; p < skt_pkg::N_PATTERNS; p++)
        begin
            if (!matched && sum.short_len == skt_pkg::PATTERNS[p].len &&
                sum.head == skt_pkg::PATTERNS[p].head)
            begin
                matched = 1'b1;
                kind    = skt_pkg::PATTERNS[p].kind;
            end
        end
        if (!matched && sum.short_len != 3'd0 &&
            sum.first_char == skt_pkg::CHAR_QUOTE && sum.last_char == skt_pkg::CHAR_QUOTE)
        begin
            kind = skt_pkg::KIND_STRING;
        end
    end

endmodule

// ----- design/skt_gather.sv -----
// skt_gather: token state (length, head, ends) and the sticky halt flag.
// Flags delimiter and overflow bytes; depends on skt_pkg.
module skt_gather
#(
    parameter int MAX_LEN = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        char_code,
    output skt_pkg::tok_sum_t sum,
    output skt_pkg::tok_evt_t evt
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int HW    = 8 * skt_pkg::HEAD_BYTES;

    logic [LEN_W-1:0] len_reg, len_next;
    logic [HW-1:0]    head_reg, head_next;
    logic [7:0]       first_reg, first_next;
    logic [7:0]       last_reg, last_next;
    logic             halted_reg, halted_next;
    logic             is_delim;
    logic             is_full;

    assign is_delim = (char_code == skt_pkg::CHAR_SPACE) ||
                      (char_code == skt_pkg::CHAR_NEWLINE);
    assign is_full  = (len_reg == LEN_W'(MAX_LEN));

    assign evt.emit     = !halted_reg && (is_delim || is_full);
    assign evt.overflow = !halted_reg && !is_delim && is_full;

    assign sum.short_len  = (len_reg > LEN_W'(6)) ? 3'd7 : len_reg[2:0];
    assign sum.head       = head_reg;
    assign sum.first_char = first_reg;
    assign sum.last_char  = last_reg;

    always_comb
    begin
        len_next    = len_reg;
        head_next   = head_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        halted_next = halted_reg;
        if (step && !halted_reg)
        begin
            if (is_delim)
            begin
                len_next   = '0;
                head_next  = '0;
                first_next = '0;
                last_next  = '0;
            end
            else if (is_full)
            begin
                halted_next = 1'b1;
            end
            else
            begin
                for (int k = 0; k < skt_pkg::HEAD_BYTES; k++)
                begin
                    if (len_reg == LEN_W'(k))
                        head_next[8*k +: 8] = char_code;
                end
                if (len_reg == '0)
                    first_next = char_code;
                last_next = char_code;
                len_next  = len_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            head_reg   <= '0;
            first_reg  <= '0;
            last_reg   <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            len_reg    <= len_next;
            head_reg   <= head_next;
            first_reg  <= first_next;
            last_reg   <= last_next;
            halted_reg <= halted_next;
        end
    end

`ifndef SYNTHESIS
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_LEN))
        else $error("token length beyond limit");
`endif

endmodule

// ----- design/sql_keyword_tokenizer.sv -----
// sql_keyword_tokenizer: top level; input byte register, token gatherer,
// classifier and result register. Depends on skt_pkg, skt_gather, skt_classify.
//
// Takes one byte of query text per cycle and emits one token kind at each space
// or newline, or one overflow result when a token passes MAX_LEN bytes, after
// which all bytes are swallowed until reset. A byte is registered, then handled
// against the token registers; its result is registered in the output register
// in the cycle after it is handled. Throughput is one byte per cycle: input
// stalls only when a delimiter or overflow byte waits while the result register
// is held.
module sql_keyword_tokenizer
#(
    parameter int MAX_LEN = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [3:0] token_kind, [7:4] zero
    output logic [0:0] m_axis_tuser    // [0] overflow_error
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_char_reg, in_char_next;
    logic              out_valid_reg, out_valid_next;
    skt_pkg::kind_t    out_kind_reg, out_kind_next;
    logic              out_ovf_reg, out_ovf_next;
    logic              step;
    logic              load_out;
    skt_pkg::tok_sum_t sum;
    skt_pkg::tok_evt_t evt;
    skt_pkg::kind_t    kind;

    skt_gather #(.MAX_LEN(MAX_LEN)) u_gather
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .char_code (in_char_reg),
        .sum       (sum),
        .evt       (evt)
    );

    skt_classify u_classify
    (
        .sum  (sum),
        .kind (kind)
    );

    assign step     = in_valid_reg && (!evt.emit || !out_valid_reg || m_axis_tready);
    assign load_out = step && evt.emit;

    assign s_axis_tready = !in_valid_reg || step;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_char_next   = in_char_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_kind_next  = out_kind_reg;
        out_ovf_next   = out_ovf_reg;
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
            in_char_next  = s_axis_tdata;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_ovf_next   = evt.overflow;
            out_kind_next  = evt.overflow ? skt_pkg::KIND_SELECT : kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_char_reg  <= in_char_next;
        out_kind_reg <= out_kind_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {4'b0000, out_kind_reg};
    assign m_axis_tuser[0] = out_ovf_reg;

`ifndef SYNTHESIS
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("result request lost");

    a_ovf_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ovf_reg |-> out_kind_reg == skt_pkg::KIND_SELECT)
        else $error("overflow result carries a token kind");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && out_valid_reg |-> m_axis_tready)
        else $error("pending result overwritten");
`endif

endmodule

// ----- tb/sv/skt_token_checker.sv -----
`timescale 1ns / 1ps
// skt_token_checker: watches both streams of sql_keyword_tokenizer, predicts the
// token kind of every delimiter and the overflow result, and compares. Uses skt_pkg.
module skt_token_checker
#(
    parameter int MAX_LEN = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // [3:0] token_kind, [7:4] zero
    input  logic [0:0] m_axis_tuser,   // [0] overflow_error
    output int         pending,
    output int         err_count
);

    typedef struct packed {
        skt_pkg::kind_t kind;
        logic           overflow;
    } token_result_t;

    token_result_t expected_tokens [$];
    token_result_t got_token;

    int          tok_len;
    logic [47:0] tok_head;
    logic [7:0]  tok_first;
    logic [7:0]  tok_last;
    logic        halted;
    logic [7:0]  in_char;
    int          errs = 0;

    assign err_count = errs;

    task automatic report(input string msg);
        errs++;
        $display("%0t ERROR: %s", $time, msg);
    endtask

    function automatic logic [47:0] pack_text(input string s);
        logic [47:0] v;
        int          k;
        v = '0;
        for (k = 0; k < s.len() && k < skt_pkg::HEAD_BYTES; k++)
        begin
            v[8*k +: 8] = s[k];
        end
        return v;
    endfunction

    function automatic logic word_is(input string s);
        return (tok_len == s.len()) && (tok_head == pack_text(s));
    endfunction

    function automatic skt_pkg::kind_t classify_token();
        if (word_is("SELECT")) return skt_pkg::KIND_SELECT;
        if (word_is("FROM"))   return skt_pkg::KIND_FROM;
        if (word_is("WHERE"))  return skt_pkg::KIND_WHERE;
        if (word_is(";"))      return skt_pkg::KIND_SEMI;
        if (word_is("AND"))    return skt_pkg::KIND_AND;
        if (word_is("OR"))     return skt_pkg::KIND_OR;
        if (word_is("+"))      return skt_pkg::KIND_PLUS;
        if (word_is("-"))      return skt_pkg::KIND_MINUS;
        if (word_is("/"))      return skt_pkg::KIND_DIVIDE;
        if (word_is("*"))      return skt_pkg::KIND_ASTERISK;
        if (word_is("="))      return skt_pkg::KIND_EQUAL;
        if (word_is(">"))      return skt_pkg::KIND_GREATER;
        if (word_is("<"))      return skt_pkg::KIND_LESS;
        if (tok_len >= 1 && tok_first == skt_pkg::CHAR_QUOTE &&
            tok_last == skt_pkg::CHAR_QUOTE)
            return skt_pkg::KIND_STRING;
        return skt_pkg::KIND_COLUMN;
    endfunction

    task automatic clear_token();
        tok_len   = 0;
        tok_head  = '0;
        tok_first = '0;
        tok_last  = '0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_token();
            halted = 1'b0;
            expected_tokens.delete();
            pending <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    report($sformatf("unexpected token result tdata=%h tuser=%b",
                                     m_axis_tdata, m_axis_tuser));
                end
                else
                begin
                    got_token = expected_tokens.pop_front();
                    if (m_axis_tuser[0] !== got_token.overflow)
                        report($sformatf("overflow_error %b, expected %b",
                                         m_axis_tuser[0], got_token.overflow));
                    if (m_axis_tdata[3:0] !== got_token.kind)
                        report($sformatf("token_kind %0d, expected %0d (%s)",
                                         m_axis_tdata[3:0], got_token.kind,
                                         got_token.kind.name()));
                    if (m_axis_tdata[7:4] !== 4'h0)
                        report($sformatf("tdata pad bits %h not zero", m_axis_tdata[7:4]));
                end
            end

            if (s_axis_tvalid && s_axis_tready && !halted)
            begin
                in_char = s_axis_tdata;
                if (in_char == skt_pkg::CHAR_SPACE || in_char == skt_pkg::CHAR_NEWLINE)
                begin
                    expected_tokens.push_back('{kind: classify_token(), overflow: 1'b0});
                    clear_token();
                end
                else if (tok_len >= MAX_LEN)
                begin
                    // kind field reads zero on overflow
                    expected_tokens.push_back('{kind: skt_pkg::KIND_SELECT,
                                                overflow: 1'b1});
                    halted = 1'b1;
                end
                else
                begin
                    if (tok_len < skt_pkg::HEAD_BYTES)
                        tok_head[8*tok_len +: 8] = in_char;
                    if (tok_len == 0)
                        tok_first = in_char;
                    tok_last = in_char;
                    tok_len++;
                end
            end

            pending <= expected_tokens.size();
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// tb: drives query bytes into sql_keyword_tokenizer with random gaps and stalls,
// and gives the verdict. Uses skt_pkg and skt_token_checker.
module tb;

    localparam int TOK_MAX     = 1024;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_BYTES  = 400;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;

    int         pending;
    int         err_count;
    int         sent = 0;
    int         hold_left = 0;
    bit         src_gaps = 1'b1;
    bit         sink_gaps = 1'b1;
    bit         hold_req = 1'b0;
    logic [7:0] tok_bytes [$];

    always #1 clk = ~clk;

    sql_keyword_tokenizer #(.MAX_LEN(TOK_MAX)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    skt_token_checker #(.MAX_LEN(TOK_MAX)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .pending       (pending),
        .err_count     (err_count)
    );

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= !(sink_gaps && $urandom_range(0, 99) < 23);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (src_gaps && $urandom_range(0, 99) < 23)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(0, 255));
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_delim();
        send_byte($urandom_range(0, 1) ? skt_pkg::CHAR_SPACE : skt_pkg::CHAR_NEWLINE);
    endtask

    task automatic send_tok();
        int k;
        for (k = 0; k < tok_bytes.size(); k++)
            send_byte(tok_bytes[k]);
        send_delim();
    endtask

    task automatic load_word(input string s);
        int k;
        tok_bytes.delete();
        for (k = 0; k < s.len(); k++)
            tok_bytes.push_back(s[k]);
    endtask

    function automatic string keyword_text(input int i);
        case (i)
            0:       return "SELECT";
            1:       return "FROM";
            2:       return "WHERE";
            3:       return ";";
            4:       return "AND";
            5:       return "OR";
            6:       return "+";
            7:       return "-";
            8:       return "/";
            9:       return "*";
            10:      return "=";
            11:      return ">";
            default: return "<";
        endcase
    endfunction

    // printable, never a delimiter
    function automatic logic [7:0] text_byte();
        return 8'($urandom_range(33, 126));
    endfunction

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic random_token();
        int r;
        int n;
        int k;
        r = $urandom_range(0, 99);
        tok_bytes.delete();
        if (r < 30)
        begin
            load_word(keyword_text($urandom_range(0, 12)));
        end
        else if (r < 45)
        begin
            tok_bytes.push_back(skt_pkg::CHAR_QUOTE);
            n = $urandom_range(0, 6);
            repeat (n) tok_bytes.push_back(text_byte());
            tok_bytes.push_back(skt_pkg::CHAR_QUOTE);
        end
        else if (r < 62)
        begin
            // near misses of a keyword
            load_word(keyword_text($urandom_range(0, 12)));
            k = $urandom_range(0, tok_bytes.size() - 1);
            case ($urandom_range(0, 3))
                0: tok_bytes[k] = tok_bytes[k] ^ (8'h01 << $urandom_range(0, 7));
                1: void'(tok_bytes.pop_back());
                2: tok_bytes.push_back($urandom_range(0, 1) ? text_byte() : 8'h00);
                default:
                begin
                    for (k = 0; k < tok_bytes.size(); k++)
                        tok_bytes[k] = tok_bytes[k] | 8'h20;
                end
            endcase
        end
        else if (r < 80)
        begin
            n = $urandom_range(1, 12);
            repeat (n) tok_bytes.push_back($urandom_range(0, 1) ?
                                           8'($urandom_range(65, 90)) :
                                           8'($urandom_range(97, 122)));
        end
        else if (r < 92)
        begin
            n = $urandom_range(1, 8);
            if ($urandom_range(0, 2) == 0)
                tok_bytes.push_back(skt_pkg::CHAR_QUOTE);
            repeat (n) tok_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 95)
        begin
            n = $urandom_range(50, 200);
            repeat (n) tok_bytes.push_back(text_byte());
            if ($urandom_range(0, 1))
            begin
                tok_bytes[0] = skt_pkg::CHAR_QUOTE;
                tok_bytes[n-1] = skt_pkg::CHAR_QUOTE;
            end
        end
        // else: empty token
        send_tok();
    endtask

    initial
    begin
        int  base;
        int  idx;
        int  k;
        bit  hold_done;
        bit  mid_drained;

        hold_done   = 1'b0;
        mid_drained = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty tokens: delimiter first, then two in a row
        send_byte(skt_pkg::CHAR_SPACE);
        send_byte(skt_pkg::CHAR_NEWLINE);
        for (k = 0; k < 13; k++)
        begin
            load_word(keyword_text(k));
            send_tok();
        end
        // lone quote is a string
        load_word("'");
        send_tok();
        drain();

        base = sent;
        while (sent - base < RAND_BYTES)
        begin
            idx = sent - base;
            if (!hold_done && idx >= 80)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            src_gaps  = !(idx >= 80 && idx < 130) && !(idx >= 150 && idx < 300);
            sink_gaps = !(idx >= 150 && idx < 300);
            if (!mid_drained && idx >= 320)
            begin
                drain();
                mid_drained = 1'b1;
            end
            random_token();
        end
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;

        // a token filled to the maximum length, one more byte overflows,
        // then everything is swallowed
        repeat (TOK_MAX + 1) send_byte(text_byte());
        repeat (20)
        begin
            if ($urandom_range(0, 3) == 0)
                send_delim();
            else
                send_byte(8'($urandom_range(0, 255)));
        end

        drain();
        repeat (16) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/skt_pkg.sv
design/skt_classify.sv
design/skt_gather.sv
design/sql_keyword_tokenizer.sv
tb/sv/skt_token_checker.sv
tb/sv/tb.sv
